// ===== hw/rtl/lbs_pkg.sv =====
// Shared types, codes and defaults for the bounded LIFO stack.
package lbs_pkg;

    localparam int DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_PEEK    = 2'd2,
        OP_DISPLAY = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] data_value;
        logic [1:0]         status;
        logic               is_empty;
        logic               is_full;
        logic               last;
    } rsp_t;

endpackage

// ===== hw/rtl/lbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/bounded_lifo_stack.sv =====
// Top level of the bounded LIFO stack: sequencer, fill count and word store.
// Push and empty-stack results come from the result register in the cycle after the request beat;
// pop/peek results pass through a RAM read (READ) and then the result register (OUT).
// One request at a time: a new request is taken only back in IDLE, after the result is taken.
// Display: each word takes a RAM read (READ), then the result register (OUT), top entry first; output stalls hold OUT.
// Reset (rst_n, async, low): fill count cleared, nothing pending; store is not cleared.
module bounded_lifo_stack #(
    parameter int DEPTH = lbs_pkg::DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_stall,
    input  lbs_pkg::req_t req,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output lbs_pkg::rsp_t rsp
);

    import lbs_pkg::*;

    // count holds 0..DEPTH, address covers 0..DEPTH-1
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  ptr_reg, ptr_next;      // entry being read
    logic           disp_reg, disp_next;    // walking for a display
    rsp_t           rsp_reg, rsp_next;

    logic           ram_we;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [31:0]    ram_rdata;
    logic [CW-1:0]  count_dec;

    lbs_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (req.push_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign count_dec = count_reg - CW'(1);

    // ------------------------------------------------------------------
    // Sequencer
    // IDLE takes a request beat. Push writes at once unless the stack is full; a read-type
    // request on a non-empty stack issues a RAM read and goes to READ, where the registered
    // word lands in the result register; other requests go straight to OUT. OUT holds the
    // result until it is taken; a display then steps the pointer down and reads again.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        disp_next  = disp_reg;
        rsp_next   = rsp_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.operation == OP_PUSH)
                    begin
                        state_next = S_OUT;
                        if (count_reg == FULL_CNT)
                        begin
                            rsp_next = '{data_value: '0, status: ST_OVERFLOW,
                                         is_empty: 1'b0, is_full: 1'b1, last: 1'b1};
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            rsp_next   = '{data_value: '0, status: ST_OK,
                                           is_empty: 1'b0,
                                           is_full: (count_next == FULL_CNT),
                                           last: 1'b1};
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // pop, peek or display on an empty stack
                        state_next = S_OUT;
                        rsp_next   = '{data_value: '0, status: ST_EMPTY,
                                       is_empty: 1'b1, is_full: 1'b0, last: 1'b1};
                    end
                    else
                    begin
                        state_next = S_READ;
                        ptr_next   = count_dec[AW-1:0];
                        ram_re     = 1'b1;
                        ram_raddr  = ptr_next;
                        disp_next  = (req.operation == OP_DISPLAY);
                        if (req.operation == OP_POP)
                        begin
                            count_next = count_dec;
                        end
                    end
                end
            end

            S_READ:
            begin
                // count already reflects a pop, so flags show the stack after the request
                state_next = S_OUT;
                rsp_next   = '{data_value: ram_rdata, status: ST_OK,
                               is_empty: (count_reg == '0),
                               is_full: (count_reg == FULL_CNT),
                               last: (!disp_reg || ptr_reg == '0)};
            end

            S_OUT:
            begin
                if (!rsp_stall)
                begin
                    if (disp_reg && ptr_reg != '0)
                    begin
                        state_next = S_READ;
                        ptr_next   = ptr_reg - AW'(1);
                        ram_re     = 1'b1;
                        ram_raddr  = ptr_next;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        disp_next  = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            disp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            disp_reg  <= disp_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count above depth");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !req_stall |-> !rsp_valid)
        else $error("request taken while a result is pending");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.operation == OP_PUSH && count_reg != FULL_CNT)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted push did not grow the stack");

    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (rsp_valid && rsp.status == ST_OK))
        else $error("store read did not produce an ok result");

endmodule
